FILE: src/tcmc_pkg.sv
// ----------------------------------------------------------------------------
// tcmc_pkg
// Shared types and constants for the two-coin minimum change unit.
// ----------------------------------------------------------------------------
package tcmc_pkg;

  localparam int unsigned W  = 16;
  localparam int unsigned CW = 16;

  typedef struct packed {
    logic [W-1:0] coin_one;
    logic [W-1:0] coin_two;
    logic [W-1:0] target;
  } tcmc_req_t;

  typedef struct packed {
    logic          found;
    logic [CW-1:0] total_count;
    logic [CW-1:0] large_count;
    logic [CW-1:0] small_count;
  } tcmc_res_t;

  // Control into the shared divide unit, and its status back
  typedef struct packed {
    logic         start;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } tcmc_div_cmd_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] quot;
    logic [W-1:0] rem;
  } tcmc_div_sts_t;

endpackage

FILE: src/two_coin_min_change_unit.sv
// ----------------------------------------------------------------------------
// two_coin_min_change_unit
// Fewest-coin split of a target over two coin values, one request at a time.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  input   | start, busy, in_req           | taken when start & !busy
//  result  | out_valid, out_res            | one-cycle strobe, no stall
//
// Steps: each divide runs on the shared divider. A request runs
// the Euclid loop (one divide per step, up to about 24 steps), three divides
// to reduce by the gcd, one for target mod big and one for small mod big,
// then a search that tries one small-coin count per cycle (up to big, about 2^16),
// then one divide for the large count.
// Reset clears the sequencer; the result cannot be stalled.
module two_coin_min_change_unit import tcmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tcmc_req_t in_req,
  output logic      out_valid,
  output tcmc_res_t out_res
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_GCD   = 12'b000000000010,
    S_GMOD  = 12'b000000000100,
    S_DN    = 12'b000000001000,
    S_D1    = 12'b000000010000,
    S_D2    = 12'b000000100000,
    S_RMOD  = 12'b000001000000,
    S_SMOD  = 12'b000010000000,
    S_SRCH  = 12'b000100000000,
    S_XDIV  = 12'b001000000000,
    S_WAIT  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } st_t;

  st_t           st_r, st_nxt;
  logic [W-1:0]  c1_r, c1_nxt, c2_r, c2_nxt, n_r, n_nxt;
  logic [W-1:0]  p_r, p_nxt, q_r, q_nxt;   // euclid pair, then big/small
  logic [W-1:0]  r_r, r_nxt, stp_r, stp_nxt, y_r, y_nxt;
  logic [W-1:0]  g_r, g_nxt;
  logic          res_v_r, res_v_nxt;
  tcmc_res_t     res_r, res_nxt;
  tcmc_div_cmd_t dcmd;
  tcmc_div_sts_t dsts;
  logic [W:0]    radd;
  logic [2*W-1:0] sy;
  logic [W-1:0]  nrest;

  tcmc_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts));

  // Modular step of the search: r - step mod big, inputs already below big
  assign radd  = (r_r >= stp_r) ? {1'b0, r_r - stp_r} : ({1'b0, r_r} + {1'b0, p_r} - {1'b0, stp_r});
  assign sy    = q_r * y_r;
  assign nrest = n_r - sy[W-1:0];

  // Sequence the shared divider
  always_comb begin
    st_nxt = st_r; c1_nxt = c1_r; c2_nxt = c2_r; n_nxt = n_r;
    p_nxt = p_r; q_nxt = q_r; r_nxt = r_r; stp_nxt = stp_r; y_nxt = y_r;
    g_nxt = g_r; res_v_nxt = 1'b0; res_nxt = res_r;
    dcmd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          c1_nxt = in_req.coin_one; c2_nxt = in_req.coin_two; n_nxt = in_req.target;
          res_nxt = '0;
          if (in_req.target == '0) begin
            res_nxt.found = 1'b1; st_nxt = S_DONE;
          end else if ((in_req.target < in_req.coin_one && in_req.target < in_req.coin_two)
                       || (in_req.coin_one == '0 && in_req.coin_two == '0)) begin
            st_nxt = S_DONE;
          end else begin
            p_nxt = in_req.coin_one; q_nxt = in_req.coin_two; st_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        // gcd(p, q): p when q is zero, else divide
        if (q_r == '0) begin
          g_nxt = p_r; dcmd.start = 1'b1; dcmd.dividend = n_r; dcmd.divisor = p_r;
          st_nxt = S_GMOD;
        end else begin
          dcmd.start = 1'b1; dcmd.dividend = p_r; dcmd.divisor = q_r; st_nxt = S_WAIT;
        end
      end
      S_WAIT: if (dsts.done) begin
        p_nxt = q_r; q_nxt = dsts.rem; st_nxt = S_GCD;
      end
      S_GMOD: if (dsts.done) begin
        if (dsts.rem != '0) st_nxt = S_DONE;
        else begin
          n_nxt = dsts.quot; dcmd.start = 1'b1; dcmd.dividend = c1_r; dcmd.divisor = g_r;
          st_nxt = S_D1;
        end
      end
      S_D1: if (dsts.done) begin
        c1_nxt = dsts.quot; dcmd.start = 1'b1; dcmd.dividend = c2_r; dcmd.divisor = g_r;
        st_nxt = S_D2;
      end
      S_D2: if (dsts.done) begin
        if (c1_r >= dsts.quot) begin p_nxt = c1_r; q_nxt = dsts.quot; end
        else begin p_nxt = dsts.quot; q_nxt = c1_r; end
        dcmd.start = 1'b1; dcmd.dividend = n_r;
        dcmd.divisor = (c1_r >= dsts.quot) ? c1_r : dsts.quot;
        st_nxt = S_RMOD;
      end
      S_RMOD: if (dsts.done) begin
        r_nxt = dsts.rem; dcmd.start = 1'b1; dcmd.dividend = q_r; dcmd.divisor = p_r;
        st_nxt = S_SMOD;
      end
      S_SMOD: if (dsts.done) begin
        stp_nxt = dsts.rem; y_nxt = '0; st_nxt = S_SRCH;
      end
      S_DN: st_nxt = S_DONE;
      S_SRCH: begin
        if (r_r != '0 && y_r < p_r) begin
          r_nxt = radd[W-1:0]; y_nxt = y_r + 1'b1;
        end else if (r_r != '0 || sy > {{W{1'b0}}, n_r}) begin
          st_nxt = S_DONE;
        end else begin
          dcmd.start = 1'b1; dcmd.dividend = nrest; dcmd.divisor = p_r; st_nxt = S_XDIV;
        end
      end
      S_XDIV: if (dsts.done) begin
        res_nxt.found = 1'b1;
        res_nxt.large_count = CW'(dsts.quot);
        res_nxt.small_count = CW'(y_r);
        res_nxt.total_count = CW'(dsts.quot + y_r);
        st_nxt = S_DONE;
      end
      S_DONE: begin
        res_v_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; res_v_r <= res_v_nxt;
    end
    c1_r <= c1_nxt; c2_r <= c2_nxt; n_r <= n_nxt; p_r <= p_nxt; q_r <= q_nxt;
    r_r <= r_nxt; stp_r <= stp_nxt; y_r <= y_nxt; g_r <= g_nxt; res_r <= res_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign out_valid = res_v_r;
  assign out_res   = res_r;

  // A result comes only out of the final state
  a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == S_DONE) else $error("result without done");
  // A result leaves the unit idle
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
  // Not found carries zero counts
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.found) |-> out_res.total_count == '0)
    else $error("counts on miss");

endmodule

FILE: src/tcmc_div.sv
// ----------------------------------------------------------------------------
// tcmc_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module tcmc_div import tcmc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  tcmc_div_cmd_t cmd,
  output tcmc_div_sts_t sts
);

  logic [W-1:0]         q_r, q_nxt;
  logic [W-1:0]         rm_r, rm_nxt;
  logic [W-1:0]         d_r, d_nxt;
  logic [$clog2(W):0]   cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [W:0]           trial;

  assign trial = {rm_r, q_r[W-1]};

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      q_nxt   = cmd.dividend;
      rm_nxt  = '0;
      d_nxt   = cmd.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rm_nxt = W'(trial - {1'b0, d_r});
        q_nxt  = {q_r[W-2:0], 1'b1};
      end else begin
        rm_nxt = trial[W-1:0];
        q_nxt  = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(W)+1)'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    d_r  <= d_nxt;
  end

  assign sts.done = done_r;
  assign sts.quot = q_r;
  assign sts.rem  = rm_r;

endmodule
